[src/yuvxf_pkg.sv]
package yuvxf_pkg;

    typedef struct packed {
        logic [7:0] luma_a;
        logic [7:0] cb_a;
        logic [7:0] cr_a;
        logic [7:0] luma_b;
        logic [7:0] cb_b;
        logic [7:0] cr_b;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] luma_out;
        logic [7:0] cb_out;
        logic [7:0] cr_out;
    } t_pix_out;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef logic signed [10:0] t_term;

    typedef struct packed {
        logic [7:0] y;
        t_term      rv;
        t_term      gu;
        t_term      gv;
        t_term      bu;
    } t_fwd_terms;

    typedef struct packed {
        t_term yr;
        t_term yg;
        t_term yb;
        t_term cbr;
        t_term cbg;
        t_term cbb;
        t_term crr;
        t_term crg;
        t_term crb;
    } t_back_terms;

    localparam logic [7:0] WEIGHT_RESET = 8'd255;
    localparam logic signed [11:0] CHROMA_OFFSET = 12'sd128;

    localparam logic signed [15:0] C_R_V  = 16'sd22970;
    localparam logic signed [15:0] C_G_U  = -16'sd5638;
    localparam logic signed [15:0] C_G_V  = -16'sd11700;
    localparam logic signed [15:0] C_B_U  = 16'sd29032;
    localparam logic signed [15:0] C_Y_R  = 16'sd4899;
    localparam logic signed [15:0] C_Y_G  = 16'sd9617;
    localparam logic signed [15:0] C_Y_B  = 16'sd1868;
    localparam logic signed [15:0] C_CB_R = -16'sd2764;
    localparam logic signed [15:0] C_CB_G = -16'sd5428;
    localparam logic signed [15:0] C_CB_B = 16'sd8192;
    localparam logic signed [15:0] C_CR_R = 16'sd8192;
    localparam logic signed [15:0] C_CR_G = -16'sd6860;
    localparam logic signed [15:0] C_CR_B = -16'sd1332;

    // Q2.14 product, truncated toward zero.
    function automatic t_term mul_q(input logic signed [15:0] coef,
                                    input logic signed [8:0] x);
        logic signed [24:0] p;
        logic signed [24:0] adj;
        p   = coef * x;
        adj = p[24] ? (p + 25'sd16383) : p;
        return t_term'(adj[24:14]);
    endfunction

    function automatic logic signed [11:0] ext_term(input t_term t);
        return {t[10], t};
    endfunction

    function automatic logic [7:0] sat8(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 12'sd0) begin
            res = 8'd0;
        end else if (v > 12'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

[src/yuvxf_to_rgb.sv]
module yuvxf_to_rgb (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  yuvxf_pkg::t_pix_in i_pixel,
    output logic               o_valid,
    output yuvxf_pkg::t_rgb    o_rgb_a,
    output yuvxf_pkg::t_rgb    o_rgb_b
);

    logic                   r_valid1;
    yuvxf_pkg::t_fwd_terms  r_terms_a;
    yuvxf_pkg::t_fwd_terms  r_terms_b;
    yuvxf_pkg::t_fwd_terms  n_terms_a;
    yuvxf_pkg::t_fwd_terms  n_terms_b;
    logic                   r_valid2;
    yuvxf_pkg::t_rgb        r_rgb_a;
    yuvxf_pkg::t_rgb        r_rgb_b;
    yuvxf_pkg::t_rgb        n_rgb_a;
    yuvxf_pkg::t_rgb        n_rgb_b;

    function automatic yuvxf_pkg::t_fwd_terms fwd_terms(input logic [7:0] y,
                                                        input logic [7:0] cb,
                                                        input logic [7:0] cr);
        yuvxf_pkg::t_fwd_terms t;
        logic signed [8:0] u;
        logic signed [8:0] v;
        u    = $signed({1'b0, cb}) - 9'sd128;
        v    = $signed({1'b0, cr}) - 9'sd128;
        t.y  = y;
        t.rv = yuvxf_pkg::mul_q(yuvxf_pkg::C_R_V, v);
        t.gu = yuvxf_pkg::mul_q(yuvxf_pkg::C_G_U, u);
        t.gv = yuvxf_pkg::mul_q(yuvxf_pkg::C_G_V, v);
        t.bu = yuvxf_pkg::mul_q(yuvxf_pkg::C_B_U, u);
        return t;
    endfunction

    function automatic yuvxf_pkg::t_rgb fwd_sum(input yuvxf_pkg::t_fwd_terms t);
        yuvxf_pkg::t_rgb c;
        logic signed [11:0] yy;
        yy  = $signed({4'b0000, t.y});
        c.r = yuvxf_pkg::sat8(yy + yuvxf_pkg::ext_term(t.rv));
        c.g = yuvxf_pkg::sat8(yy + yuvxf_pkg::ext_term(t.gu)
                              + yuvxf_pkg::ext_term(t.gv));
        c.b = yuvxf_pkg::sat8(yy + yuvxf_pkg::ext_term(t.bu));
        return c;
    endfunction

    always_comb begin
        n_terms_a = fwd_terms(i_pixel.luma_a, i_pixel.cb_a, i_pixel.cr_a);
        n_terms_b = fwd_terms(i_pixel.luma_b, i_pixel.cb_b, i_pixel.cr_b);
        n_rgb_a   = fwd_sum(r_terms_a);
        n_rgb_b   = fwd_sum(r_terms_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms_a <= n_terms_a;
        r_terms_b <= n_terms_b;
        r_rgb_a   <= n_rgb_a;
        r_rgb_b   <= n_rgb_b;
    end

    assign o_valid = r_valid2;
    assign o_rgb_a = r_rgb_a;
    assign o_rgb_b = r_rgb_b;

endmodule

[src/yuvxf_mix.sv]
module yuvxf_mix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_weight,
    input  yuvxf_pkg::t_rgb i_rgb_a,
    input  yuvxf_pkg::t_rgb i_rgb_b,
    output logic            o_valid,
    output yuvxf_pkg::t_rgb o_rgb
);

    logic            r_valid;
    yuvxf_pkg::t_rgb r_rgb;
    yuvxf_pkg::t_rgb n_rgb;
    logic [8:0]      weight_b;

    function automatic logic [7:0] mix(input logic [7:0] ca,
                                       input logic [7:0] cb,
                                       input logic [7:0] wa,
                                       input logic [8:0] wb);
        logic [16:0] acc;
        acc = ({9'd0, ca} * {9'd0, wa}) + ({9'd0, cb} * {8'd0, wb});
        return acc[15:8];
    endfunction

    assign weight_b = 9'd256 - {1'b0, i_weight};

    always_comb begin
        n_rgb.r = mix(i_rgb_a.r, i_rgb_b.r, i_weight, weight_b);
        n_rgb.g = mix(i_rgb_a.g, i_rgb_b.g, i_weight, weight_b);
        n_rgb.b = mix(i_rgb_a.b, i_rgb_b.b, i_weight, weight_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb <= n_rgb;
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

[src/yuvxf_to_ycc.sv]
module yuvxf_to_ycc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  yuvxf_pkg::t_rgb     i_rgb,
    output logic                o_valid,
    output yuvxf_pkg::t_pix_out o_pixel
);

    logic                   r_valid1;
    yuvxf_pkg::t_back_terms r_terms;
    yuvxf_pkg::t_back_terms n_terms;
    logic                   r_valid2;
    yuvxf_pkg::t_pix_out    r_pixel;
    yuvxf_pkg::t_pix_out    n_pixel;
    logic signed [8:0]      r_in;
    logic signed [8:0]      g_in;
    logic signed [8:0]      b_in;

    assign r_in = $signed({1'b0, i_rgb.r});
    assign g_in = $signed({1'b0, i_rgb.g});
    assign b_in = $signed({1'b0, i_rgb.b});

    always_comb begin
        n_terms.yr  = yuvxf_pkg::mul_q(yuvxf_pkg::C_Y_R,  r_in);
        n_terms.yg  = yuvxf_pkg::mul_q(yuvxf_pkg::C_Y_G,  g_in);
        n_terms.yb  = yuvxf_pkg::mul_q(yuvxf_pkg::C_Y_B,  b_in);
        n_terms.cbr = yuvxf_pkg::mul_q(yuvxf_pkg::C_CB_R, r_in);
        n_terms.cbg = yuvxf_pkg::mul_q(yuvxf_pkg::C_CB_G, g_in);
        n_terms.cbb = yuvxf_pkg::mul_q(yuvxf_pkg::C_CB_B, b_in);
        n_terms.crr = yuvxf_pkg::mul_q(yuvxf_pkg::C_CR_R, r_in);
        n_terms.crg = yuvxf_pkg::mul_q(yuvxf_pkg::C_CR_G, g_in);
        n_terms.crb = yuvxf_pkg::mul_q(yuvxf_pkg::C_CR_B, b_in);
    end

    always_comb begin
        n_pixel.luma_out = yuvxf_pkg::sat8(yuvxf_pkg::ext_term(r_terms.yr)
                                           + yuvxf_pkg::ext_term(r_terms.yg)
                                           + yuvxf_pkg::ext_term(r_terms.yb));
        n_pixel.cb_out   = yuvxf_pkg::sat8(yuvxf_pkg::ext_term(r_terms.cbr)
                                           + yuvxf_pkg::ext_term(r_terms.cbg)
                                           + yuvxf_pkg::ext_term(r_terms.cbb)
                                           + yuvxf_pkg::CHROMA_OFFSET);
        n_pixel.cr_out   = yuvxf_pkg::sat8(yuvxf_pkg::ext_term(r_terms.crr)
                                           + yuvxf_pkg::ext_term(r_terms.crg)
                                           + yuvxf_pkg::ext_term(r_terms.crb)
                                           + yuvxf_pkg::CHROMA_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms <= n_terms;
        r_pixel <= n_pixel;
    end

    assign o_valid = r_valid2;
    assign o_pixel = r_pixel;

endmodule

[src/yuv_crossfade_blend_top.sv]
// Cross-fade of two full-range YCbCr pixel streams.
// Input: a pixel pair on i_pixel is transferred at each rising edge with start
// high and busy low. The block never asserts busy, so a pair may enter in
// every cycle.
// Output: each blended pixel appears on o_pixel for exactly one cycle with
// o_strobe high, in input order.
// Throughput is one pixel per clock through a five-stage pipeline: forward
// products, RGB sums, weighted mix, backward products, YCbCr sums.
// The receiver cannot stall the block and every result must be taken.
// Configuration: i_cfg_we writes i_cfg_wdata into the blend weight, the share
// of the first source out of 256. Write it only while no pixel is in flight.
// Reset (synchronous, active low) empties the pipeline and sets the weight
// to 255.
module yuv_crossfade_blend_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  yuvxf_pkg::t_pix_in  i_pixel,
    output logic                o_strobe,
    output yuvxf_pkg::t_pix_out o_pixel,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_wdata
);

    logic [7:0]      r_blend_weight;
    logic            in_valid;
    logic            rgb_valid;
    yuvxf_pkg::t_rgb rgb_a;
    yuvxf_pkg::t_rgb rgb_b;
    logic            mix_valid;
    yuvxf_pkg::t_rgb rgb_mix;

    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight <= yuvxf_pkg::WEIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_blend_weight <= i_cfg_wdata;
            end
        end
    end

    yuvxf_to_rgb u_to_rgb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_pixel (i_pixel),
        .o_valid (rgb_valid),
        .o_rgb_a (rgb_a),
        .o_rgb_b (rgb_b)
    );

    yuvxf_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rgb_valid),
        .i_weight (r_blend_weight),
        .i_rgb_a  (rgb_a),
        .i_rgb_b  (rgb_b),
        .o_valid  (mix_valid),
        .o_rgb    (rgb_mix)
    );

    yuvxf_to_ycc u_to_ycc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_valid),
        .i_rgb   (rgb_mix),
        .o_valid (o_strobe),
        .o_pixel (o_pixel)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("Transfer did not produce a result five cycles later.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("Result strobe without a matching input transfer.");

    a_mix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rgb_valid |=> mix_valid)
        else $error("Mix stage dropped a valid pixel.");
`endif

endmodule
